// File: rtl/core/lrsm_pkg.sv
package lrsm_pkg;

    // Default widths of the sample and of the position fraction.
    localparam int STEP_FRAC_BITS_DEF = 20;
    localparam int SAMPLE_BITS_DEF    = 16;

    // Fixed field widths and limits.
    localparam int STEP_BITS     = 25;
    localparam int CFG_IDX_BITS  = 1;
    localparam int MAX_RESULTS   = 49;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_STEP_RATIO  = 1'b0,
        REG_MONO_SOURCE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_FRAME = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_FLUSH
    } seq_state_t;

    // Control that travels alongside each interpolation tap.
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctrl_t;

endpackage

// File: rtl/core/lrsm_lane.sv
module lrsm_lane #(
    parameter int STEP_FRAC_BITS = lrsm_pkg::STEP_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = lrsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic signed [SAMPLE_BITS-1:0] b,
    input  logic [STEP_FRAC_BITS-1:0]     t,
    output logic signed [SAMPLE_BITS-1:0] res
);
    import lrsm_pkg::*;

    localparam int PW = SAMPLE_BITS + STEP_FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF =
        {{(PW-STEP_FRAC_BITS){1'b0}}, 1'b1, {(STEP_FRAC_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PW-1:0]          diff_ext;
    logic signed [PW-1:0]          t_ext;
    logic signed [PW-1:0]          prod_next;
    logic signed [PW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          shifted;

    assign diff      = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
    assign diff_ext  = PW'(diff);
    assign t_ext     = signed'(PW'(t));
    assign prod_next = diff_ext * t_ext;

    // Multiply stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
    end

    // Round half up, floor shift, add to the earlier sample.
    assign rounded = prod_reg + HALF;
    assign shifted = rounded >>> STEP_FRAC_BITS;
    assign res     = a_reg + shifted[SAMPLE_BITS-1:0];

endmodule

// File: rtl/core/lrsm_merge.sv
module lrsm_merge #(
    parameter int SAMPLE_BITS = lrsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrsm_pkg::beat_ctrl_t          tap_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] left_res,
    input  logic signed [SAMPLE_BITS-1:0] right_res,
    output logic                          adv,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_left,
    output logic signed [SAMPLE_BITS-1:0] m_out_right,
    output logic                          m_last_of_run
);
    import lrsm_pkg::*;

    beat_ctrl_t                    ctrl1_reg;
    logic                          valid_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;

    // The whole pipe moves whenever the output register is free or being emptied.
    assign adv = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            valid_reg <= 1'b0;
        end else if (adv) begin
            ctrl1_reg <= tap_ctrl;
            valid_reg <= ctrl1_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_reg  <= left_res;
            right_reg <= right_res;
            last_reg  <= ctrl1_reg.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_left    = left_reg;
    assign m_out_right   = right_reg;
    assign m_last_of_run = last_reg;

endmodule

// File: rtl/core/lrsm_seq.sv
module lrsm_seq #(
    parameter int STEP_FRAC_BITS = lrsm_pkg::STEP_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = lrsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_write,
    input  logic [lrsm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lrsm_pkg::STEP_BITS-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_ch1,
    input  logic                               adv,
    output lrsm_pkg::beat_ctrl_t               tap_ctrl,
    output logic signed [SAMPLE_BITS-1:0]      left_a,
    output logic signed [SAMPLE_BITS-1:0]      left_b,
    output logic signed [SAMPLE_BITS-1:0]      right_a,
    output logic signed [SAMPLE_BITS-1:0]      right_b,
    output logic [STEP_FRAC_BITS-1:0]          tap_t
);
    import lrsm_pkg::*;

    localparam int POS_W = ((STEP_BITS > STEP_FRAC_BITS) ? STEP_BITS : STEP_FRAC_BITS + 1) + 1;
    localparam logic [POS_W-1:0] POS_ONE =
        {{(POS_W-STEP_FRAC_BITS-1){1'b0}}, 1'b1, {STEP_FRAC_BITS{1'b0}}};
    localparam logic [STEP_BITS-1:0] STEP_FLOOR =
        STEP_BITS'(((64'd1 << STEP_FRAC_BITS) + 64'(MAX_RESULTS) - 64'd1) / 64'(MAX_RESULTS));
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(64'd1 << STEP_FRAC_BITS);

    seq_state_t                    state_reg, state_next;
    logic [STEP_BITS-1:0]          step_reg;
    logic                          mono_reg;
    logic signed [SAMPLE_BITS-1:0] held_l_reg, held_l_next;
    logic signed [SAMPLE_BITS-1:0] held_r_reg, held_r_next;
    logic                          held_valid_reg, held_valid_next;
    logic signed [SAMPLE_BITS-1:0] cur_l_reg, cur_l_next;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg, cur_r_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [POS_W-1:0]              pos_step;
    logic [POS_W-1:0]              pos_step2;
    logic signed [SAMPLE_BITS-1:0] in_r;
    logic                          accept;

    assign accept    = s_valid && s_ready;
    assign in_r      = mono_reg ? s_sample_ch0 : s_sample_ch1;
    assign pos_step  = pos_reg + POS_W'(step_reg);
    assign pos_step2 = pos_step + POS_W'(step_reg);

    // Configuration; the step is held already raised to its floor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            mono_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_RATIO:  step_reg <= (cfg_data < STEP_FLOOR) ? STEP_FLOOR : cfg_data;
                REG_MONO_SOURCE: mono_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_valid_reg <= 1'b0;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            pos_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            held_l_reg     <= held_l_next;
            held_r_reg     <= held_r_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
    end

    always_comb begin
        state_next      = state_reg;
        held_valid_next = held_valid_reg;
        held_l_next     = held_l_reg;
        held_r_next     = held_r_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        pos_next        = pos_reg;
        s_ready         = 1'b0;
        tap_ctrl        = '0;
        left_a          = held_l_reg;
        right_a         = held_r_reg;
        left_b          = held_l_reg;
        right_b         = held_r_reg;
        tap_t           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (req_type_t'(s_req_type) == REQ_FLUSH) begin
                        if (held_valid_reg && (pos_step <= POS_ONE)) begin
                            state_next = ST_FLUSH;
                        end else begin
                            held_valid_next = 1'b0;
                            held_l_next     = '0;
                            held_r_next     = '0;
                            pos_next        = '0;
                        end
                    end else if (!held_valid_reg) begin
                        held_valid_next = 1'b1;
                        held_l_next     = s_sample_ch0;
                        held_r_next     = in_r;
                    end else if (pos_reg < POS_ONE) begin
                        cur_l_next = s_sample_ch0;
                        cur_r_next = in_r;
                        state_next = ST_FRAME;
                    end else begin
                        pos_next    = pos_reg - POS_ONE;
                        held_l_next = s_sample_ch0;
                        held_r_next = in_r;
                    end
                end
            end
            ST_FRAME: begin
                tap_ctrl.valid = 1'b1;
                tap_ctrl.last  = (pos_step >= POS_ONE);
                left_b         = cur_l_reg;
                right_b        = cur_r_reg;
                tap_t          = pos_reg[STEP_FRAC_BITS-1:0];
                if (adv) begin
                    pos_next = pos_step;
                    if (tap_ctrl.last) begin
                        pos_next    = pos_step - POS_ONE;
                        held_l_next = cur_l_reg;
                        held_r_next = cur_r_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                tap_ctrl.valid = 1'b1;
                tap_ctrl.last  = (pos_step2 > POS_ONE);
                if (adv) begin
                    pos_next = pos_step;
                    if (tap_ctrl.last) begin
                        held_valid_next = 1'b0;
                        held_l_next     = '0;
                        held_r_next     = '0;
                        pos_next        = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/linear_resampler_stereo_mix_top.sv
// Linear-interpolation sample-rate converter with mono to stereo up-mix.
// The s_ channel carries one source frame per beat (s_req_type low) or an
// end-of-sound marker (s_req_type high). The m_ channel carries the output
// samples, one stereo pair per beat, with m_last_of_run set on the final
// beat that an input beat causes. The cfg_ channel writes the step ratio
// (index 0) and mono mode (index 1); it is always ready and must only be
// used while the block is idle.
// An input beat that produces results holds s_ready low after it is taken,
// while the sequencer issues one interpolation tap per cycle unless the output
// stalls, and that sets the rate, up to 49 results per source frame. A beat
// with no result leaves s_ready high.
// Each tap passes through the lane multiply register and then the output
// register before it appears on the m_ channel.
// A stalled receiver freezes the whole tap pipeline; no beat is lost, and a
// new input beat can still be taken while the last result waits.
// Reset clears the held frame and the read position and restores a step of
// 1.0 and stereo mode; no clearing pass is needed.
module linear_resampler_stereo_mix_top #(
    parameter int STEP_FRAC_BITS = lrsm_pkg::STEP_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = lrsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrsm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [lrsm_pkg::STEP_BITS-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_ch1,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]     m_out_left,
    output logic signed [SAMPLE_BITS-1:0]     m_out_right,
    output logic                              m_last_of_run
);
    import lrsm_pkg::*;

    beat_ctrl_t                    tap_ctrl;
    logic                          adv;
    logic signed [SAMPLE_BITS-1:0] left_a;
    logic signed [SAMPLE_BITS-1:0] left_b;
    logic signed [SAMPLE_BITS-1:0] right_a;
    logic signed [SAMPLE_BITS-1:0] right_b;
    logic [STEP_FRAC_BITS-1:0]     tap_t;
    logic signed [SAMPLE_BITS-1:0] left_res;
    logic signed [SAMPLE_BITS-1:0] right_res;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // The sequencer walks the read position across the current source interval.
    lrsm_seq #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_sample_ch0 (s_sample_ch0),
        .s_sample_ch1 (s_sample_ch1),
        .adv          (adv),
        .tap_ctrl     (tap_ctrl),
        .left_a       (left_a),
        .left_b       (left_b),
        .right_a      (right_a),
        .right_b      (right_b),
        .tap_t        (tap_t)
    );

    // Two identical interpolation lanes, one per output channel.
    lrsm_lane #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_lane_left (
        .aclk (aclk),
        .adv  (adv),
        .a    (left_a),
        .b    (left_b),
        .t    (tap_t),
        .res  (left_res)
    );

    lrsm_lane #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_lane_right (
        .aclk (aclk),
        .adv  (adv),
        .a    (right_a),
        .b    (right_b),
        .t    (tap_t),
        .res  (right_res)
    );

    // The merge stage pairs both lanes into one output beat and owns the stall.
    lrsm_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tap_ctrl      (tap_ctrl),
        .left_res      (left_res),
        .right_res     (right_res),
        .adv           (adv),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_left    (m_out_left),
        .m_out_right   (m_out_right),
        .m_last_of_run (m_last_of_run)
    );

endmodule
